// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SPQ_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int ITEM_BITS_DEF     = 32;
	localparam int PRIORITY_BITS_DEF = 24;

	localparam int STEPS_BITS     = 4;
	localparam int COUNT_OUT_BITS = 5;

	// neighbor link between cells
	typedef struct packed {
		logic valid;
		logic stay;
	} link_t;

endpackage

// ===== rtl/spq_if.sv =====
interface spq_req_if import spq_pkg::*; #(
	parameter int ITEM_BITS     = ITEM_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [ITEM_BITS-1:0]     entry_item;
	logic [PRIORITY_BITS-1:0] entry_priority;

	modport source (output valid, entry_item, entry_priority, input ready);
	modport sink (input valid, entry_item, entry_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; #(
	parameter int ITEM_BITS     = ITEM_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
);
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic [STEPS_BITS-1:0]     steps_counted;
	logic [COUNT_OUT_BITS-1:0] entry_count;
	logic                      queue_empty;
	logic [ITEM_BITS-1:0]      top_item;
	logic [PRIORITY_BITS-1:0]  top_priority;

	modport source (output valid, accepted, steps_counted, entry_count, queue_empty,
		top_item, top_priority, input ready);
	modport sink (input valid, accepted, steps_counted, entry_count, queue_empty,
		top_item, top_priority, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
module spq_cell import spq_pkg::*; #(
	parameter int IDX           = 0,
	parameter int ITEM_BITS     = ITEM_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
	parameter int CNT_BITS      = 5
) (
	input  logic                     clk,
	input  logic                     ins_en,
	input  logic [ITEM_BITS-1:0]     new_item,
	input  logic [PRIORITY_BITS-1:0] new_priority,
	input  logic [CNT_BITS-1:0]      count,
	input  link_t                    prev_link,
	input  logic [ITEM_BITS-1:0]     prev_item,
	input  logic [PRIORITY_BITS-1:0] prev_priority,
	output link_t                    link,
	output logic [ITEM_BITS-1:0]     cur_item,
	output logic [PRIORITY_BITS-1:0] cur_priority,
	output logic                     pos_hit
);

	logic [ITEM_BITS-1:0]     item_q;
	logic [PRIORITY_BITS-1:0] priority_q;
	logic                     is_valid;
	logic                     stays;
	logic                     take_new;
	logic                     take_prev;

	always_comb begin
		is_valid = (CNT_BITS'(IDX) < count);
		if (IDX == 0) begin
			stays = is_valid && !(new_priority > priority_q);
		end else begin
			stays = is_valid && (priority_q > new_priority);
		end
		take_new  = !stays && prev_link.stay;
		take_prev = prev_link.valid && !prev_link.stay;
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (take_new) begin
				item_q     <= new_item;
				priority_q <= new_priority;
			end else if (take_prev) begin
				item_q     <= prev_item;
				priority_q <= prev_priority;
			end
		end
	end

	assign link         = '{valid: is_valid, stay: stays};
	assign cur_item     = item_q;
	assign cur_priority = priority_q;
	assign pos_hit      = take_new;

endmodule

// ===== rtl/sorted_insert_priority_queue_unit.sv =====
// The response for a request is registered and presented in the cycle after the request is taken.
// Throughput: one request per cycle unless a held response stalls req.ready; every cell compares
// the new priority in the same cycle and shifts toward its neighbor, so the cell row sets the rate.
// Reset (arst_n low, asynchronous): entry count and response valid clear; the cells'
// contents are left as they are and are never read before being written.
module sorted_insert_priority_queue_unit import spq_pkg::*; #(
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int ITEM_BITS     = ITEM_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	`include "assert_macros.svh"

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_BITS-1:0]      count_q;
	logic                     rsp_valid_q;
	logic                     accepted_q;
	logic [STEPS_BITS-1:0]    steps_q;
	logic [COUNT_OUT_BITS-1:0] entry_count_q;
	logic                     empty_q;
	logic [ITEM_BITS-1:0]     top_item_q;
	logic [PRIORITY_BITS-1:0] top_priority_q;

	link_t                    links     [QUEUE_DEPTH];
	logic [ITEM_BITS-1:0]     items     [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] prios     [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   pos_hit;

	logic                     req_fire;
	logic                     has_room;
	logic                     ins_en;
	logic [CNT_BITS-1:0]      new_count;
	logic [STEPS_BITS-1:0]    steps;
	logic [ITEM_BITS-1:0]     new_top_item;
	logic [PRIORITY_BITS-1:0] new_top_priority;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign has_room  = (count_q != CNT_BITS'(QUEUE_DEPTH));
	assign ins_en    = req_fire && has_room;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		link_t                    prev_link;
		logic [ITEM_BITS-1:0]     prev_item;
		logic [PRIORITY_BITS-1:0] prev_priority;

		if (i == 0) begin : g_head
			assign prev_link     = '{valid: 1'b0, stay: 1'b1};
			assign prev_item     = '0;
			assign prev_priority = '0;
		end else begin : g_body
			assign prev_link     = links[i-1];
			assign prev_item     = items[i-1];
			assign prev_priority = prios[i-1];
		end

		spq_cell #(
			.IDX           (i),
			.ITEM_BITS     (ITEM_BITS),
			.PRIORITY_BITS (PRIORITY_BITS),
			.CNT_BITS      (CNT_BITS)
		) u_cell (
			.clk           (clk),
			.ins_en        (ins_en),
			.new_item      (req.entry_item),
			.new_priority  (req.entry_priority),
			.count         (count_q),
			.prev_link     (prev_link),
			.prev_item     (prev_item),
			.prev_priority (prev_priority),
			.link          (links[i]),
			.cur_item      (items[i]),
			.cur_priority  (prios[i]),
			.pos_hit       (pos_hit[i])
		);
	end

	always_comb begin
		steps = '0;
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			if (pos_hit[i]) begin
				steps = steps | STEPS_BITS'(i - 1);
			end
		end
		if (!has_room) begin
			steps = '0;
		end
		new_count = count_q + CNT_BITS'(has_room);
		if (has_room && pos_hit[0]) begin
			new_top_item     = req.entry_item;
			new_top_priority = req.entry_priority;
		end else begin
			new_top_item     = items[0];
			new_top_priority = prios[0];
		end
		if (new_count == '0) begin
			new_top_item     = '0;
			new_top_priority = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				count_q <= new_count;
			end
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			accepted_q     <= has_room;
			steps_q        <= steps;
			entry_count_q  <= COUNT_OUT_BITS'(new_count);
			empty_q        <= (new_count == '0);
			top_item_q     <= new_top_item;
			top_priority_q <= new_top_priority;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.accepted      = accepted_q;
	assign rsp.steps_counted = steps_q;
	assign rsp.entry_count   = entry_count_q;
	assign rsp.queue_empty   = empty_q;
	assign rsp.top_item      = top_item_q;
	assign rsp.top_priority  = top_priority_q;

	`SPQ_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_BITS'(QUEUE_DEPTH), "count overflow")
	`SPQ_ASSERT(a_count_inc, clk, arst_n, ins_en |=> count_q == $past(count_q) + CNT_BITS'(1), "count not incremented")
	`SPQ_ASSERT(a_full_hold, clk, arst_n, (req_fire && !has_room) |=> $stable(count_q), "refused request changed count")
	`SPQ_ASSERT(a_sorted_head, clk, arst_n, (count_q >= CNT_BITS'(2)) |-> prios[1] <= prios[0], "store out of order")

endmodule

// ===== test/spq_insert_checker.sv =====
`timescale 1ns / 100ps

module spq_insert_checker import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if        req,
	spq_rsp_if        rsp,
	output int        mismatch_count,
	output int        pending_count,
	output int        inserted_count,
	output int        refused_count
);

	typedef struct packed {
		logic                         accepted;
		logic [STEPS_BITS-1:0]        steps_counted;
		logic [COUNT_OUT_BITS-1:0]    entry_count;
		logic                         queue_empty;
		logic [ITEM_BITS_DEF-1:0]     top_item;
		logic [PRIORITY_BITS_DEF-1:0] top_priority;
	} insert_status_t;

	logic [PRIORITY_BITS_DEF-1:0] shadow_priority [QUEUE_DEPTH_DEF];
	logic [ITEM_BITS_DEF-1:0]     shadow_item [QUEUE_DEPTH_DEF];
	int                           shadow_count = 0;

	insert_status_t expected_status [$];
	int errors = 0;
	int inserted = 0;
	int refused = 0;

	// sorted insert into the shadow store; equal priorities after the top keep newest first
	function automatic insert_status_t insert_sorted(logic [ITEM_BITS_DEF-1:0] item,
		logic [PRIORITY_BITS_DEF-1:0] prio);
		insert_status_t st;
		int slot;
		st = '0;
		if (shadow_count < QUEUE_DEPTH_DEF) begin
			if (shadow_count == 0 || prio > shadow_priority[0]) begin
				slot = 0;
			end else begin
				slot = 1;
				while (slot < shadow_count && shadow_priority[slot] > prio)
					slot++;
				st.steps_counted = STEPS_BITS'(slot - 1);
			end
			for (int k = shadow_count; k > slot; k--) begin
				shadow_priority[k] = shadow_priority[k-1];
				shadow_item[k] = shadow_item[k-1];
			end
			shadow_priority[slot] = prio;
			shadow_item[slot] = item;
			shadow_count++;
			st.accepted = 1'b1;
		end
		st.entry_count = COUNT_OUT_BITS'(shadow_count);
		st.queue_empty = (shadow_count == 0);
		if (shadow_count != 0) begin
			st.top_item = shadow_item[0];
			st.top_priority = shadow_priority[0];
		end
		return st;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		insert_status_t seen;
		insert_status_t want;
		if (!arst_n) begin
			shadow_count = 0;
			expected_status.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.accepted = rsp.accepted;
				seen.steps_counted = rsp.steps_counted;
				seen.entry_count = rsp.entry_count;
				seen.queue_empty = rsp.queue_empty;
				seen.top_item = rsp.top_item;
				seen.top_priority = rsp.top_priority;
				if (expected_status.size() == 0) begin
					report_mismatch("response with no request outstanding", 32'(seen.entry_count),
						32'h0);
				end else begin
					want = expected_status.pop_front();
					if (seen.accepted !== want.accepted)
						report_mismatch("accepted", 32'(seen.accepted), 32'(want.accepted));
					if (seen.steps_counted !== want.steps_counted)
						report_mismatch("steps_counted", 32'(seen.steps_counted),
							32'(want.steps_counted));
					if (seen.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(seen.entry_count),
							32'(want.entry_count));
					if (seen.queue_empty !== want.queue_empty)
						report_mismatch("queue_empty", 32'(seen.queue_empty),
							32'(want.queue_empty));
					if (seen.top_item !== want.top_item)
						report_mismatch("top_item", 32'(seen.top_item), 32'(want.top_item));
					if (seen.top_priority !== want.top_priority)
						report_mismatch("top_priority", 32'(seen.top_priority),
							32'(want.top_priority));
				end
			end
			if (req.valid && req.ready) begin
				want = insert_sorted(req.entry_item, req.entry_priority);
				if (want.accepted)
					inserted++;
				else
					refused++;
				expected_status.push_back(want);
			end
		end
		mismatch_count <= errors;
		pending_count <= expected_status.size();
		inserted_count <= inserted;
		refused_count <= refused;
	end

endmodule

// ===== test/sorted_insert_priority_queue_unit_test.sv =====
`timescale 1ns / 100ps

module sorted_insert_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int STALL_LIMIT    = 1000;
	localparam int RANDOM_REQUESTS = 780;
	localparam int CALM_REQUESTS   = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         req_valid = 1'b0;
	logic [ITEM_BITS_DEF-1:0]     req_item = '0;
	logic [PRIORITY_BITS_DEF-1:0] req_priority = '0;
	logic                         rsp_ready = 1'b0;
	logic                         bursts_on = 1'b1;
	int                           stall_left = 0;
	int                           quiet_cycles = 0;

	int mismatch_count;
	int pending_count;
	int inserted_count;
	int refused_count;

	spq_req_if req_if ();
	spq_rsp_if rsp_if ();

	assign req_if.valid = req_valid;
	assign req_if.entry_item = req_item;
	assign req_if.entry_priority = req_priority;
	assign rsp_if.ready = rsp_ready;

	sorted_insert_priority_queue_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	spq_insert_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.inserted_count (inserted_count),
		.refused_count  (refused_count)
	);

	always #10 clk = ~clk;

	// response side back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(logic [ITEM_BITS_DEF-1:0] item,
		logic [PRIORITY_BITS_DEF-1:0] prio);
		int gap;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= item;
		req_priority <= prio;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		logic [PRIORITY_BITS_DEF-1:0] prio;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the store: empty head, ties with the top and behind it, new head, tail
		send_request(32'h0000_0000, 24'h80_0000);
		send_request(32'hFFFF_FFFF, 24'h80_0000);
		send_request(32'hA5A5_A5A5, 24'hFF_FFFF);
		send_request(32'h5A5A_5A5A, 24'h00_0000);
		send_request(32'h0000_0001, 24'h80_0000);
		send_request(32'h0000_0002, 24'h7F_FFFF);
		send_request(32'h0000_0003, 24'hFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_request($urandom, 24'h10_0000 - 24'(i * 3));
		send_request($urandom, 24'h00_0001);
		// store is full now
		send_request(32'hFFFF_FFFF, 24'hFF_FFFF);
		send_request(32'h0000_0000, 24'h00_0000);
		send_request($urandom, 24'h80_0000);
		drain_responses();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - CALM_REQUESTS)
				bursts_on <= 1'b0;
			case ($urandom_range(0, 5))
				0: prio = '0;
				1: prio = '1;
				2: prio = 24'h80_0000;
				default: prio = PRIORITY_BITS_DEF'($urandom);
			endcase
			send_request($urandom, prio);
			if (i % 200 == 199)
				drain_responses();
		end
		drain_responses();
		repeat (5) @(posedge clk);

		$display("covered %0d requests: %0d inserted in priority order, %0d refused while full",
			inserted_count + refused_count, inserted_count, refused_count);
		$display("%0d field mismatches", mismatch_count);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_insert_priority_queue_unit.sv
test/spq_insert_checker.sv
test/sorted_insert_priority_queue_unit_test.sv
